FILE: rtl/glyph_code_remap_manager_top_assert.svh
// Assertion macros for the glyph code remap manager.
// Used by files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef GLYPH_CODE_REMAP_MANAGER_TOP_ASSERT_SVH
`define GLYPH_CODE_REMAP_MANAGER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// check a property while out of reset
`define GCRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check a property at every edge, reset included
`define GCRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GCRM_ASSERT(lbl, prop, msg)
`define GCRM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/gcrm_pkg.sv
// Shared types and constants for the glyph code remap manager.
// No dependencies; imported by every module of the block but gcrm_ram.
`timescale 1ns / 1ps
package gcrm_pkg;

    localparam int GLYPH_SLOTS   = 188;
    localparam int TABLE_ENTRIES = 512;
    localparam int BYTE_CODES    = 256;

    localparam int TBL_AW  = $clog2(TABLE_ENTRIES);
    localparam int TBL_CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_IW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
    localparam int SCAN_W  = $clog2(GLYPH_SLOTS + 1);
    localparam int BYTE_AW = (BYTE_CODES > 1) ? $clog2(BYTE_CODES) : 1;
    localparam int HINT_W  = 8;

    typedef enum logic [1:0] {
        OP_LOOKUP    = 2'd0,
        OP_MAP_ROM   = 2'd1,
        OP_MAP_GLYPH = 2'd2,
        OP_MAP_BYTE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_R1_BASE = 2'd0,
        CFG_R1_END  = 2'd1,
        CFG_R2_BASE = 2'd2,
        CFG_R2_END  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] code;
        logic [15:0] rom_code;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [15:0] result_code;
    } t_out_item;

    // one table entry: original code and its substitute
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] alt;
    } t_entry;

    typedef enum logic [1:0] {
        TBL_HOLD    = 2'd0,
        TBL_ROTATE  = 2'd1,
        TBL_REPLACE = 2'd2,
        TBL_INSERT  = 2'd3
    } t_tbl_op;

    // command broadcast to every table cell
    typedef struct packed {
        t_tbl_op     op;
        logic [15:0] key;
        logic [15:0] alt;
    } t_tbl_cmd;

endpackage

FILE: rtl/glyph_code_remap_manager_top.sv
// Glyph code remap manager: one transaction in, one result out, one at a time.
// A lookup or a map to a ROM code turns the table ring once past its head cell.
// A map to a new glyph slot adds the slot bitmap scan, one slot a cycle. A map
// of an 8-bit code reads the byte map and then runs that scan, without turning
// the ring. No clearing pass is needed after reset; the block is ready at once.
// A finished result waits in the output register while the next transaction is taken.
// Depends on gcrm_pkg, gcrm_table and gcrm_ram.
`timescale 1ns / 1ps
`include "glyph_code_remap_manager_top_assert.svh"
module glyph_code_remap_manager_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gcrm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gcrm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import gcrm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_POST, S_BREAD, S_BCHK, S_ASTART, S_SCAN, S_ENTER, S_DONE
    } t_state;

    function automatic logic code_ok(input logic [15:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = c[7:0];
        hi = c[15:8];
        return (lo >= 8'h20) && (lo < 8'h80) && (hi >= 8'h20) && (hi < 8'h80);
    endfunction

    t_state                r_state, n_state;
    t_opcode               r_op, n_op;
    logic [15:0]           r_code, n_code;
    logic [15:0]           r_rom, n_rom;
    logic                  r_found, n_found;
    logic [15:0]           r_alt, n_alt;
    logic [15:0]           r_newalt, n_newalt;
    logic [TBL_AW-1:0]     r_step, n_step;
    logic [SCAN_W-1:0]     r_scan, n_scan;
    logic                  r_pass, n_pass;
    t_status               r_status, n_status;
    logic [15:0]           r_result, n_result;
    logic [GLYPH_SLOTS-1:0] r_used, n_used;
    logic [SCAN_W-1:0]     r_used_cnt, n_used_cnt;
    logic [HINT_W-1:0]     r_hint, n_hint;
    logic [BYTE_CODES-1:0] r_bvalid, n_bvalid;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;
    logic [15:0]           r_r1_base, r_r1_end, r_r2_base, r_r2_end;

    t_tbl_cmd              tbl_cmd;
    t_entry                tbl_head;
    logic [TBL_CW-1:0]     tbl_count;

    logic                  ram_we;
    logic [15:0]           ram_wdata;
    logic [15:0]           ram_rdata;
    logic [BYTE_AW-1:0]    byte_addr;
    logic [15:0]           byte_old;

    logic [15:0]           span;
    logic                  free_en;
    logic [15:0]           free_code;
    logic                  free_in;
    logic [15:0]           free_idx;
    logic                  free_hit;
    logic [15:0]           scan_glyph;
    logic                  alloc_fail;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign byte_addr   = r_code[BYTE_AW-1:0];
    assign byte_old    = r_bvalid[byte_addr] ? ram_rdata : 16'h0000;
    assign span        = r_r1_end - r_r1_base;

    // map the freed glyph code back to its slot
    always_comb begin
        free_in = !((free_code < r_r1_base) || (free_code >= r_r2_end))
                  && !((free_code >= r_r1_end) && (free_code < r_r2_base));
        if (free_code >= r_r2_base) begin
            free_idx = free_code - r_r2_base + span;
        end else begin
            free_idx = free_code - r_r1_base;
        end
        free_hit = free_en && free_in && (free_idx < 16'(GLYPH_SLOTS));
    end

    // glyph code of the slot under the scan
    always_comb begin
        if (16'(r_scan) >= span) begin
            scan_glyph = 16'(r_scan) + r_r2_base - span;
        end else begin
            scan_glyph = 16'(r_scan) + r_r1_base;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_base <= 16'd30241;
            r_r1_end  <= 16'd30335;
            r_r2_base <= 16'd30497;
            r_r2_end  <= 16'd30591;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_R1_BASE: r_r1_base <= i_cfg_data;
                CFG_R1_END:  r_r1_end  <= i_cfg_data;
                CFG_R2_BASE: r_r2_base <= i_cfg_data;
                CFG_R2_END:  r_r2_end  <= i_cfg_data;
                default:     r_r1_base <= r_r1_base;
            endcase
        end
    end

    // sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_code      = r_code;
        n_rom       = r_rom;
        n_found     = r_found;
        n_alt       = r_alt;
        n_newalt    = r_newalt;
        n_step      = r_step;
        n_scan      = r_scan;
        n_pass      = r_pass;
        n_status    = r_status;
        n_result    = r_result;
        n_used      = r_used;
        n_used_cnt  = r_used_cnt;
        n_hint      = r_hint;
        n_bvalid    = r_bvalid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        tbl_cmd     = '{op: TBL_HOLD, key: r_code, alt: r_newalt};
        ram_we      = 1'b0;
        ram_wdata   = scan_glyph;
        free_en     = 1'b0;
        free_code   = r_alt;
        alloc_fail  = 1'b0;

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.opcode;
                    n_code   = i_in_data.code;
                    n_rom    = i_in_data.rom_code;
                    n_found  = 1'b0;
                    n_alt    = '0;
                    n_step   = '0;
                    n_status = ST_OK;
                    n_result = '0;
                    case (i_in_data.opcode)
                        OP_LOOKUP: begin
                            n_state = S_SEARCH;
                        end
                        OP_MAP_BYTE: begin
                            if (i_in_data.code >= 16'(BYTE_CODES)) begin
                                n_status = ST_INVALID;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_BREAD;
                            end
                        end
                        default: begin
                            if (!code_ok(i_in_data.code)) begin
                                n_status = ST_INVALID;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // turn the ring once, watching the head cell
                tbl_cmd.op = TBL_ROTATE;
                if ((TBL_CW'(r_step) < tbl_count) && (tbl_head.key == r_code)) begin
                    n_found = 1'b1;
                    n_alt   = tbl_head.alt;
                end
                if (r_step == TBL_AW'(TABLE_ENTRIES - 1)) begin
                    n_step  = '0;
                    n_state = S_POST;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_POST: begin
                case (r_op)
                    OP_LOOKUP: begin
                        n_result = r_found ? r_alt : r_code;
                        n_state  = S_DONE;
                    end
                    OP_MAP_ROM: begin
                        free_en = r_found;
                        if (!code_ok(r_rom)) begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            n_newalt = r_rom;
                            n_state  = S_ENTER;
                        end
                    end
                    OP_MAP_GLYPH: begin
                        free_en = r_found;
                        n_state = S_ASTART;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_BREAD: begin
                // wait for the byte map read
                n_state = S_BCHK;
            end
            S_BCHK: begin
                free_code = byte_old;
                free_en   = (byte_old != 16'h0000);
                n_state   = S_ASTART;
            end
            S_ASTART: begin
                if (r_used_cnt >= SCAN_W'(GLYPH_SLOTS)) begin
                    alloc_fail = 1'b1;
                end else begin
                    n_scan  = SCAN_W'(r_hint);
                    n_pass  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan >= SCAN_W'(GLYPH_SLOTS)) begin
                    n_hint = '0;
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_scan = '0;
                    end else begin
                        alloc_fail = 1'b1;
                    end
                end else if (r_used[r_scan[SLOT_IW-1:0]]) begin
                    n_scan = r_scan + 1'b1;
                end else begin
                    // claim the free slot
                    n_used[r_scan[SLOT_IW-1:0]] = 1'b1;
                    n_used_cnt = r_used_cnt + 1'b1;
                    n_hint     = HINT_W'({1'b0, r_scan} + 1'b1);
                    n_newalt   = scan_glyph;
                    if (r_op == OP_MAP_BYTE) begin
                        ram_we              = 1'b1;
                        n_bvalid[byte_addr] = 1'b1;
                        n_result            = scan_glyph;
                        n_state             = S_DONE;
                    end else begin
                        n_state = S_ENTER;
                    end
                end
            end
            S_ENTER: begin
                if (r_found) begin
                    tbl_cmd.op = TBL_REPLACE;
                    n_result   = (r_op == OP_MAP_GLYPH) ? r_newalt : 16'h0000;
                end else if (tbl_count >= TBL_CW'(TABLE_ENTRIES)) begin
                    n_status = ST_NOSPACE;
                end else begin
                    tbl_cmd.op = TBL_INSERT;
                    n_result   = (r_op == OP_MAP_GLYPH) ? r_newalt : 16'h0000;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free; found is for lookups only
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: r_status,
                                    found: (r_op == OP_LOOKUP) && r_found,
                                    result_code: r_result};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // release a slot
        if (free_hit) begin
            if (r_used[free_idx[SLOT_IW-1:0]]) begin
                n_used[free_idx[SLOT_IW-1:0]] = 1'b0;
                n_used_cnt = r_used_cnt - 1'b1;
            end
            n_hint = free_idx[HINT_W-1:0];
        end

        // no slot left
        if (alloc_fail) begin
            n_status = ST_NOSPACE;
            if (r_op == OP_MAP_BYTE) begin
                n_bvalid[byte_addr] = 1'b0;
            end
            n_state = S_DONE;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_used      <= '0;
            r_used_cnt  <= '0;
            r_hint      <= '0;
            r_bvalid    <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_used      <= n_used;
            r_used_cnt  <= n_used_cnt;
            r_hint      <= n_hint;
            r_bvalid    <= n_bvalid;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_pass      <= n_pass;
        end
        r_op     <= n_op;
        r_code   <= n_code;
        r_rom    <= n_rom;
        r_alt    <= n_alt;
        r_newalt <= n_newalt;
        r_scan   <= n_scan;
        r_status <= n_status;
        r_result <= n_result;
        r_out    <= n_out;
    end

    gcrm_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .o_head  (tbl_head),
        .o_count (tbl_count)
    );

    gcrm_ram #(
        .WIDTH (16),
        .DEPTH (BYTE_CODES)
    ) u_byte_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (byte_addr),
        .i_wdata (ram_wdata),
        .i_raddr (byte_addr),
        .o_rdata (ram_rdata)
    );

    `GCRM_ASSERT(a_used_cnt_max, r_used_cnt <= SCAN_W'(GLYPH_SLOTS), "slot count overflow")
    `GCRM_ASSERT(a_tbl_cnt_max, tbl_count <= TBL_CW'(TABLE_ENTRIES), "table count overflow")
    `GCRM_ASSERT(a_accept_busy, (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE), "no busy after accept")
    `GCRM_ASSERT(a_ring_aligned, (r_state == S_POST) |-> (r_step == '0), "table ring not aligned")
    `GCRM_ASSERT_ALWAYS(a_found_op, (r_state == S_SCAN && r_op == OP_MAP_BYTE) |-> !r_found, "byte map marked found")

endmodule

FILE: rtl/gcrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gcrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gcrm_cell.sv
// One cell of the sorted remap table: holds one entry and trades it with
// its neighbors. Depends on gcrm_pkg.
`timescale 1ns / 1ps
module gcrm_cell (
    input  logic              i_clk,
    input  gcrm_pkg::t_tbl_cmd i_cmd,
    input  logic              i_valid,
    input  gcrm_pkg::t_entry  i_left,
    input  logic              i_left_lt,
    input  gcrm_pkg::t_entry  i_right,
    output gcrm_pkg::t_entry  o_entry,
    output logic              o_lt
);
    import gcrm_pkg::*;

    t_entry r_entry;
    logic   match;

    // compare the stored key against the broadcast key
    always_comb begin
        o_lt  = i_valid && (r_entry.key < i_cmd.key);
        match = i_valid && (r_entry.key == i_cmd.key);
    end

    // rotate, replace in place, or open a gap and insert
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            TBL_ROTATE: begin
                r_entry <= i_right;
            end
            TBL_REPLACE: begin
                if (match) begin
                    r_entry.alt <= i_cmd.alt;
                end
            end
            TBL_INSERT: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        r_entry <= '{key: i_cmd.key, alt: i_cmd.alt};
                    end else begin
                        r_entry <= i_left;
                    end
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    assign o_entry = r_entry;

endmodule

FILE: rtl/gcrm_table.sv
// Sorted remap table built as a ring of gcrm_cell, plus the entry count.
// Depends on gcrm_pkg and gcrm_cell.
`timescale 1ns / 1ps
module gcrm_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gcrm_pkg::t_tbl_cmd         i_cmd,
    output gcrm_pkg::t_entry           o_head,
    output logic [gcrm_pkg::TBL_CW-1:0] o_count
);
    import gcrm_pkg::*;

    t_entry              entries [TABLE_ENTRIES];
    logic                lts     [TABLE_ENTRIES];
    logic [TBL_CW-1:0]   r_count;

    // row of cells; cell 0 is the head seen by the search
    for (genvar j = 0; j < TABLE_ENTRIES; j++) begin : g_cell
        t_entry left;
        logic   left_lt;
        logic   valid;

        if (j == 0) begin : g_first
            assign left    = '0;
            assign left_lt = 1'b1;
        end else begin : g_rest
            assign left    = entries[j-1];
            assign left_lt = lts[j-1];
        end

        assign valid = r_count > TBL_CW'(j);

        gcrm_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (i_cmd),
            .i_valid   (valid),
            .i_left    (left),
            .i_left_lt (left_lt),
            .i_right   (entries[(j + 1) % TABLE_ENTRIES]),
            .o_entry   (entries[j]),
            .o_lt      (lts[j])
        );
    end

    // count entries as they are inserted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.op == TBL_INSERT) begin
            r_count <= r_count + 1'b1;
        end
    end

    assign o_head  = entries[0];
    assign o_count = r_count;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for glyph_code_remap_manager_top: directed cases, random traffic, a table fill.
// Holds its own model of the remap table, the slot bitmap and the byte map.
// Depends on gcrm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
    import gcrm_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    glyph_code_remap_manager_top dut (.*);

    // mirror of the block state
    logic [15:0] reg_r1_base, reg_r1_end, reg_r2_base, reg_r2_end;
    bit          slot_busy[GLYPH_SLOTS];
    int          busy_count;
    int          next_hint;
    logic [31:0] remap_tbl[TABLE_ENTRIES];
    int          tbl_count;
    logic [15:0] byte_glyph[BYTE_CODES];

    t_out_item   pending_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;

    // directed stimulus row; want is checked only when typed
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    function automatic bit code_in_range(logic [15:0] c);
        return c[7:0] >= 8'h20 && c[7:0] < 8'h80 && c[15:8] >= 8'h20 && c[15:8] < 8'h80;
    endfunction

    function automatic logic [15:0] region_span();
        return reg_r1_end - reg_r1_base;
    endfunction

    function automatic int tbl_search(logic [15:0] key);
        int lo, hi, mid;
        lo = 0;
        hi = tbl_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (remap_tbl[mid][31:16] == key) return mid;
            if (remap_tbl[mid][31:16] < key) lo = mid + 1;
            else hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic bit take_slot(output logic [15:0] glyph);
        int s;
        glyph = '0;
        if (busy_count >= GLYPH_SLOTS) return 0;
        for (int pass = 0; pass < 2; pass++) begin
            s = (pass == 0) ? next_hint : 0;
            while (s < GLYPH_SLOTS && slot_busy[s]) s++;
            if (s < GLYPH_SLOTS) begin
                slot_busy[s] = 1;
                busy_count++;
                next_hint = (s + 1) & 8'hff;
                if (s >= region_span()) glyph = 16'(s) + reg_r2_base - region_span();
                else glyph = 16'(s) + reg_r1_base;
                return 1;
            end
            next_hint = 0;
        end
        return 0;
    endfunction

    function automatic void release_glyph(logic [15:0] c);
        logic [15:0] idx;
        if (c < reg_r1_base || c >= reg_r2_end) return;
        if (c >= reg_r1_end && c < reg_r2_base) return;
        if (c >= reg_r2_base) idx = c - reg_r2_base + region_span();
        else idx = c - reg_r1_base;
        if (idx >= GLYPH_SLOTS) return;
        if (slot_busy[idx]) begin
            slot_busy[idx] = 0;
            busy_count--;
        end
        next_hint = idx[7:0];
    endfunction

    function automatic t_status tbl_store(logic [15:0] key, logic [15:0] alt);
        int f, i;
        f = tbl_search(key);
        if (f >= 0) begin
            remap_tbl[f] = {key, alt};
            return ST_OK;
        end
        if (tbl_count >= TABLE_ENTRIES) return ST_NOSPACE;
        i = 0;
        while (i < tbl_count && remap_tbl[i][31:16] < key) i++;
        for (int k = tbl_count; k > i; k--) remap_tbl[k] = remap_tbl[k-1];
        remap_tbl[i] = {key, alt};
        tbl_count++;
        return ST_OK;
    endfunction

    // advance the mirror by one transaction and return its result
    function automatic t_out_item predict_remap(t_in_item it);
        t_out_item   r;
        logic [15:0] glyph;
        int          f;
        r = '{status: ST_OK, found: 1'b0, result_code: 16'h0};
        case (it.opcode)
            OP_LOOKUP: begin
                f = tbl_search(it.code);
                if (f >= 0) begin
                    r.found = 1'b1;
                    r.result_code = remap_tbl[f][15:0];
                end else begin
                    r.result_code = it.code;
                end
            end
            OP_MAP_BYTE: begin
                if (it.code >= BYTE_CODES) begin
                    r.status = ST_INVALID;
                end else begin
                    if (byte_glyph[it.code] != 0) begin
                        release_glyph(byte_glyph[it.code]);
                        byte_glyph[it.code] = 0;
                    end
                    if (!take_slot(glyph)) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        byte_glyph[it.code] = glyph;
                        r.result_code = glyph;
                    end
                end
            end
            default: begin
                if (!code_in_range(it.code)) begin
                    r.status = ST_INVALID;
                end else begin
                    f = tbl_search(it.code);
                    if (f >= 0) release_glyph(remap_tbl[f][15:0]);
                    if (it.opcode == OP_MAP_ROM) begin
                        if (!code_in_range(it.rom_code)) r.status = ST_INVALID;
                        else r.status = tbl_store(it.code, it.rom_code);
                    end else if (!take_slot(glyph)) begin
                        r.status = ST_NOSPACE;
                    end else begin
                        r.status = tbl_store(it.code, glyph);
                        if (r.status == ST_OK) r.result_code = glyph;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // safety limit
    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    // drive receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                errors++;
            end else begin
                w = pending_q.pop_front();
                if (o_out_data.status !== w.status || o_out_data.found !== w.found ||
                    o_out_data.result_code !== w.result_code) begin
                    $display("%0t: mismatch expected %p actual %p", $time, w, o_out_data);
                    errors++;
                end
            end
        end
    end

    // send one transaction; hold it until taken
    task automatic send_item(t_in_item it, bit typed = 0, t_out_item want = '0);
        t_out_item p;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        p = predict_remap(it);
        pending_q.push_back(typed ? want : p);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_R1_BASE: reg_r1_base = val;
            CFG_R1_END:  reg_r1_end  = val;
            CFG_R2_BASE: reg_r2_base = val;
            default:     reg_r2_end  = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regions(logic [15:0] b1, logic [15:0] e1, logic [15:0] b2,
                               logic [15:0] e2);
        drain();
        write_reg(CFG_R1_BASE, b1);
        write_reg(CFG_R1_END, e1);
        write_reg(CFG_R2_BASE, b2);
        write_reg(CFG_R2_END, e2);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return {8'($urandom_range(8'h20, 8'h7f)), 8'($urandom_range(8'h20, 8'h7f))};
            default: return {8'($urandom_range(8'h20, 8'h21)), 8'($urandom_range(8'h20, 8'h3f))};
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode   = t_opcode'($urandom_range(3));
        it.code     = pick_code();
        it.rom_code = ($urandom_range(9) == 0) ? 16'($urandom) :
                      {8'($urandom_range(8'h20, 8'h7f)), 8'($urandom_range(8'h20, 8'h7f))};
        if (it.opcode == OP_MAP_BYTE && $urandom_range(9) != 0)
            it.code = 16'($urandom_range(255));
        return it;
    endfunction

    localparam t_out_item R_OK = '{status: ST_OK, found: 1'b0, result_code: 16'h0};
    localparam t_out_item R_BAD = '{status: ST_INVALID, found: 1'b0, result_code: 16'h0};

    t_row rows[] = '{
        '{'{OP_LOOKUP, 16'h0000, 16'h0000}, 1, R_OK},
        '{'{OP_LOOKUP, 16'hffff, 16'hffff}, 1, '{ST_OK, 1'b0, 16'hffff}},
        '{'{OP_MAP_ROM, 16'h2020, 16'h7f7f}, 1, R_OK},
        '{'{OP_LOOKUP, 16'h2020, 16'h0000}, 1, '{ST_OK, 1'b1, 16'h7f7f}},
        '{'{OP_MAP_ROM, 16'h1f20, 16'h2020}, 1, R_BAD},
        '{'{OP_MAP_ROM, 16'h2080, 16'h2020}, 1, R_BAD},
        '{'{OP_MAP_ROM, 16'h8020, 16'h2020}, 1, R_BAD},
        '{'{OP_MAP_GLYPH, 16'h201f, 16'h0000}, 1, R_BAD},
        '{'{OP_MAP_ROM, 16'h7f7f, 16'h2020}, 1, R_OK},
        '{'{OP_MAP_ROM, 16'h2121, 16'h7f80}, 1, R_BAD},
        '{'{OP_MAP_GLYPH, 16'h3030, 16'h0000}, 1, '{ST_OK, 1'b0, 16'd30241}},
        '{'{OP_MAP_GLYPH, 16'h3030, 16'h0000}, 1, '{ST_OK, 1'b0, 16'd30241}},
        '{'{OP_MAP_GLYPH, 16'h3131, 16'hffff}, 0, R_OK},
        '{'{OP_LOOKUP, 16'h3030, 16'h0000}, 0, R_OK},
        '{'{OP_MAP_ROM, 16'h3030, 16'h4141}, 0, R_OK},
        '{'{OP_MAP_ROM, 16'h3131, 16'h2020}, 0, R_OK},
        '{'{OP_MAP_BYTE, 16'h0000, 16'h0000}, 0, R_OK},
        '{'{OP_MAP_BYTE, 16'h00ff, 16'h0000}, 0, R_OK},
        '{'{OP_MAP_BYTE, 16'h0100, 16'h0000}, 1, R_BAD},
        '{'{OP_MAP_BYTE, 16'hffff, 16'h0000}, 1, R_BAD},
        '{'{OP_MAP_BYTE, 16'h00ff, 16'h0000}, 0, R_OK},
        '{'{OP_MAP_GLYPH, 16'h7f20, 16'h0000}, 0, R_OK},
        '{'{OP_MAP_GLYPH, 16'h207f, 16'h0000}, 0, R_OK},
        '{'{OP_LOOKUP, 16'h7f20, 16'h0000}, 0, R_OK}
    };

    initial begin
        t_in_item it;
        int       n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reg_r1_base = 16'd30241;
        reg_r1_end = 16'd30335;
        reg_r2_base = 16'd30497;
        reg_r2_end = 16'd30591;
        foreach (slot_busy[i]) slot_busy[i] = 0;
        foreach (remap_tbl[i]) remap_tbl[i] = '0;
        foreach (byte_glyph[i]) byte_glyph[i] = '0;
        busy_count = 0;
        next_hint = 0;
        tbl_count = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the directed table
        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

        // exhaust the slots through byte codes, then hit no space on a glyph map
        for (int b = 0; b < 200; b++) send_item('{OP_MAP_BYTE, 16'(b), 16'h0});
        send_item('{OP_MAP_GLYPH, 16'h5555, 16'h0});

        // random traffic in three idle profiles, each under its own region setting
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: set_regions(16'd30241, 16'd30335, 16'd30497, 16'd30591);
                1: set_regions(16'h0000, 16'hffff, 16'hffff, 16'hffff);
                default: set_regions(16'hffff, 16'h0000, 16'h0000, 16'h00c0);
            endcase
            send_idle_pct  = (ph == 0) ? 24 : (ph == 1) ? 49 : 0;
            recv_stall_pct = (ph == 0) ? 49 : (ph == 1) ? 24 : 0;
            for (int k = 0; k < 100; k++) send_item(random_item());
        end

        // fill the table to capacity, then free a slot and overflow with a glyph map
        set_regions(16'd30241, 16'd30335, 16'd30497, 16'd30591);
        n = 0;
        while (tbl_count < TABLE_ENTRIES && n < 4000) begin
            it = '{OP_MAP_ROM, {8'($urandom_range(8'h22, 8'h7f)),
                   8'($urandom_range(8'h20, 8'h7f))}, 16'h4141};
            send_item(it);
            n++;
        end
        send_item('{OP_MAP_ROM, 16'h2020, 16'h4242});
        send_item('{OP_MAP_BYTE, 16'h0005, 16'h0});
        send_item('{OP_MAP_ROM, 16'h2121, 16'h2020});
        send_item('{OP_MAP_GLYPH, 16'h2130, 16'h0});
        send_item('{OP_MAP_GLYPH, 16'h2131, 16'h0});
        send_item('{OP_LOOKUP, 16'h2130, 16'h0});

        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
